// ===== rtl/core/led_matrix_multiplex_scanner_assert.svh =====
// Assertion macros for the checker file of the LED matrix scanner.
// Each macro expands to one labelled concurrent assertion that reports by $error.
`ifndef LED_MATRIX_MULTIPLEX_SCANNER_ASSERT_SVH
`define LED_MATRIX_MULTIPLEX_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LMMS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LMMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lmms_pkg.sv =====
// Shared types and constants of the LED matrix multiplex scanner.
// No dependencies; used by the section RAM, the top level and the testbench.
`timescale 1ns / 1ps

package lmms_pkg;

  // Fixed panel geometry and field widths.
  localparam int SECTIONS     = 4;
  localparam int SECTION_ROWS = 16;
  localparam int LOCAL_W      = 4;
  localparam int COL_W        = 8;
  localparam int BYTE_W       = 5;
  localparam int PERIOD_W     = 16;
  localparam int CFG_IDX_W    = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PERIOD       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_REVERSED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_LEVEL     = 2'd2;

  localparam logic [PERIOD_W-1:0] ROW_PERIOD_RESET = 16'd1024;

  // Write and read strobes of one section RAM.
  typedef struct packed {
    logic wr_red;
    logic wr_green;
    logic rd;
  } ram_ctl_t;

  // Per-request information carried from the input stage to the result stage.
  typedef struct packed {
    logic                shift;
    logic                strobe;
    logic [LOCAL_W-1:0]  address;
    logic                enable;
    logic [2:0]          bit_sel;
    logic                byte_ok;
    logic [SECTIONS-1:0] sec_ok;
  } scan_meta_t;

endpackage

// ===== rtl/core/lmms_section_ram.sv =====
// Red and green framebuffer bytes of one panel section, one write and one read port.
// Depends on lmms_pkg for the control struct.
`timescale 1ns / 1ps

module lmms_section_ram #(
  parameter int DEPTH  = 400,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  lmms_pkg::ram_ctl_t ctl,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_red,
  output logic [7:0]        rd_green
);
  import lmms_pkg::*;

  logic [7:0] red_mem   [DEPTH];
  logic [7:0] green_mem [DEPTH];

  // Writes; a clearing pass sets both planes at once.
  always_ff @(posedge clk) begin
    if (ctl.wr_red) begin
      red_mem[wr_addr] <= wr_data;
    end
    if (ctl.wr_green) begin
      green_mem[wr_addr] <= wr_data;
    end
  end

  // Registered read of both planes.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_red   <= red_mem[rd_addr];
      rd_green <= green_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/led_matrix_multiplex_scanner.sv =====
// LED matrix multiplex scanner: an accepted request passes the input stage, then the result register.
// One request is taken every cycle while in_stall is low; the result register and the input stage form a pipeline.
// After reset the framebuffer is cleared one address a cycle through every address of each
// section RAM, while in_stall stays high; configuration writes are taken throughout.
// Reset clears the scan state and configuration to their defaults.
`timescale 1ns / 1ps

module led_matrix_multiplex_scanner #(
  parameter int PANEL_WIDTH = 200,
  parameter int PANEL_ROWS  = 64,
  parameter int ROW_BYTES   = 25
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [lmms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmms_pkg::PERIOD_W-1:0]     cfg_data,
  // input requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic                              plane,
  input  logic [5:0]                        pixel_row,
  input  logic [lmms_pkg::BYTE_W-1:0]       byte_index,
  input  logic [7:0]                        byte_value,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lmms_pkg::SECTIONS-1:0]     red_lines,
  output logic [lmms_pkg::SECTIONS-1:0]     green_lines,
  output logic                              shift_clock,
  output logic                              strobe_res,
  output logic [lmms_pkg::LOCAL_W-1:0]      row_address,
  output logic                              output_enable
);
  import lmms_pkg::*;

  localparam int DEPTH    = SECTION_ROWS * ROW_BYTES;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int NUM_SECT = (PANEL_ROWS + SECTION_ROWS - 1) / SECTION_ROWS;

  // Configuration registers
  logic [PERIOD_W-1:0] row_period;
  logic                columns_reversed;
  logic                enable_active_level;

  // Scan state
  logic [LOCAL_W-1:0]  local_row;
  logic [PERIOD_W-1:0] period_count;
  logic [LOCAL_W-1:0]  shown_address;
  logic                lit;

  // Clearing pass
  logic                clr_active;
  logic [ADDR_W-1:0]   clr_addr;

  // Pipeline
  logic                s1_valid;
  scan_meta_t          s1_meta;
  scan_meta_t          meta_next;
  logic                s1_advance;
  logic                in_accept;
  logic                is_tick;
  logic                is_write;

  // Tick decode
  logic                in_shift;
  logic                in_latch;
  logic                tick_lit;
  logic                period_end;
  logic [COL_W-1:0]    col;
  logic [BYTE_W-1:0]   col_byte;
  logic                byte_ok;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SECTIONS-1:0] sec_ok;

  // Write decode
  logic                wr_ok;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   ram_wr_addr;
  logic [7:0]          ram_wr_data;

  logic [7:0]          red_rd   [SECTIONS];
  logic [7:0]          green_rd [SECTIONS];
  logic [SECTIONS-1:0] red_bits;
  logic [SECTIONS-1:0] green_bits;

  // Handshake
  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = clr_active || (s1_valid && !s1_advance);
  assign in_accept  = in_valid && !in_stall;
  assign is_tick    = in_accept && kind;
  assign is_write   = in_accept && !kind;

  // Phase of the row period and the column shifted this tick.
  always_comb begin
    in_shift   = period_count < PERIOD_W'(PANEL_WIDTH);
    in_latch   = period_count == PERIOD_W'(PANEL_WIDTH);
    tick_lit   = !(in_shift || in_latch);
    period_end = ({1'b0, period_count} + 17'd1) >= {1'b0, row_period};
    col        = columns_reversed ? (COL_W'(PANEL_WIDTH - 1) - period_count[COL_W-1:0])
                                  : period_count[COL_W-1:0];
    col_byte   = col[COL_W-1:3];
    byte_ok    = {1'b0, col_byte} < (BYTE_W + 1)'(ROW_BYTES);
    rd_addr    = byte_ok ? ADDR_W'(int'(local_row) * ROW_BYTES + int'(col_byte)) : '0;
    for (int s = 0; s < SECTIONS; s++) begin
      sec_ok[s] = (7'(s * SECTION_ROWS) + {3'b000, local_row}) < 7'(PANEL_ROWS);
    end
  end

  // Framebuffer write address; out-of-range writes are dropped.
  always_comb begin
    wr_ok = is_write && ({1'b0, byte_index} < (BYTE_W + 1)'(ROW_BYTES))
                     && ({1'b0, pixel_row} < 7'(PANEL_ROWS));
    wr_addr     = ADDR_W'(int'(pixel_row[3:0]) * ROW_BYTES + int'(byte_index));
    ram_wr_addr = clr_active ? clr_addr : wr_addr;
    ram_wr_data = clr_active ? 8'h00 : byte_value;
  end

  // Information the result stage needs for this request.
  always_comb begin
    meta_next.shift   = kind && in_shift;
    meta_next.strobe  = kind && in_latch;
    meta_next.address = (kind && in_latch) ? local_row : shown_address;
    meta_next.enable  = ~((kind ? tick_lit : lit) ^ enable_active_level);
    meta_next.bit_sel = col[2:0];
    meta_next.byte_ok = byte_ok;
    meta_next.sec_ok  = sec_ok;
  end

  // Section RAMs; sections beyond the panel read as zero.
  for (genvar s = 0; s < SECTIONS; s++) begin : g_sect
    if (s < NUM_SECT) begin : g_ram
      ram_ctl_t ctl;
      always_comb begin
        ctl.wr_red   = clr_active || (wr_ok && pixel_row[5:4] == 2'(s) && !plane);
        ctl.wr_green = clr_active || (wr_ok && pixel_row[5:4] == 2'(s) && plane);
        ctl.rd       = is_tick && in_shift && byte_ok;
      end
      lmms_section_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
      ) u_ram (
        .clk      (clk),
        .ctl      (ctl),
        .wr_addr  (ram_wr_addr),
        .wr_data  (ram_wr_data),
        .rd_addr  (rd_addr),
        .rd_red   (red_rd[s]),
        .rd_green (green_rd[s])
      );
    end else begin : g_none
      assign red_rd[s]   = 8'h00;
      assign green_rd[s] = 8'h00;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_period          <= ROW_PERIOD_RESET;
      columns_reversed    <= 1'b0;
      enable_active_level <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_PERIOD:       row_period          <= cfg_data;
        REG_COLUMNS_REVERSED: columns_reversed    <= cfg_data[0];
        REG_ENABLE_LEVEL:     enable_active_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Row scan state, advanced by each accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_row     <= '0;
      period_count  <= '0;
      shown_address <= '0;
      lit           <= 1'b0;
    end else if (is_tick) begin
      lit <= tick_lit;
      if (in_latch) begin
        shown_address <= local_row;
      end
      if (period_end) begin
        period_count <= '0;
        local_row    <= local_row + 1'b1;
      end else begin
        period_count <= period_count + 1'b1;
      end
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance || !s1_valid) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_meta <= meta_next;
    end
  end

  // Pick the column bit of each section from the registered bytes.
  always_comb begin
    for (int s = 0; s < SECTIONS; s++) begin
      red_bits[s]   = red_rd[s][s1_meta.bit_sel] && s1_meta.byte_ok
                      && s1_meta.sec_ok[s] && s1_meta.shift;
      green_bits[s] = green_rd[s][s1_meta.bit_sel] && s1_meta.byte_ok
                      && s1_meta.sec_ok[s] && s1_meta.shift;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      red_lines     <= red_bits;
      green_lines   <= green_bits;
      shift_clock   <= s1_meta.shift;
      strobe_res    <= s1_meta.strobe;
      row_address   <= s1_meta.address;
      output_enable <= s1_meta.enable;
    end
  end

endmodule

// ===== rtl/core/lmms_checker.sv =====
// Port-level checks of the LED matrix scanner, bound to the top level.
// Depends on led_matrix_multiplex_scanner_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "led_matrix_multiplex_scanner_assert.svh"

module lmms_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] red_lines,
  input logic [3:0] green_lines,
  input logic       shift_clock,
  input logic       strobe_res,
  input logic [3:0] row_address,
  input logic       output_enable
);

  // A stalled result holds its payload.
  `LMMS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(red_lines) && $stable(green_lines) && $stable(shift_clock) && $stable(strobe_res) && $stable(row_address) && $stable(output_enable), "stalled result changed")

  // Shift and latch never fall in the same tick.
  `LMMS_ASSERT_IMPLY(a_phase_excl, clk, rst, out_valid, !(shift_clock && strobe_res), "shift and strobe together")

  // Data lines are quiet unless a column is shifted.
  `LMMS_ASSERT_IMPLY(a_data_quiet, clk, rst, out_valid && !shift_clock, red_lines == 4'h0 && green_lines == 4'h0, "data lines driven outside shift")

  // The framebuffer clearing pass holds off requests straight after reset.
  `LMMS_ASSERT_IMPLY(a_clear_stall, clk, rst, $past(rst), in_stall && !out_valid, "request path open during clearing")

endmodule

bind led_matrix_multiplex_scanner lmms_checker u_lmms_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench of the LED matrix multiplex scanner, driving requests and configuration.
// Depends on lmms_pkg and led_matrix_multiplex_scanner; the expected pin levels come from a
// predictor in this file that keeps its own framebuffer, scan position and register copies.
`timescale 1ns / 1ps

module tb_top;
  import lmms_pkg::*;

  localparam int PANEL_WIDTH  = 200;
  localparam int PANEL_ROWS   = 64;
  localparam int ROW_BYTES    = 25;
  localparam int FB_DEPTH     = PANEL_ROWS * ROW_BYTES;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;

  // Request kinds and colour planes.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam logic PLANE_RED   = 1'b0;
  localparam logic PLANE_GREEN = 1'b1;

  typedef struct packed {
    logic       kind;
    logic       plane;
    logic [5:0] pixel_row;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
  } scan_req_t;

  typedef struct packed {
    logic [SECTIONS-1:0] red;
    logic [SECTIONS-1:0] green;
    logic                sclk;
    logic                strobe;
    logic [LOCAL_W-1:0]  addr;
    logic                oe;
  } pins_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PERIOD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic plane = 1'b0;
  logic [5:0] pixel_row = '0;
  logic [BYTE_W-1:0] byte_index = '0;
  logic [7:0] byte_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SECTIONS-1:0] red_lines;
  logic [SECTIONS-1:0] green_lines;
  logic shift_clock;
  logic strobe_res;
  logic [LOCAL_W-1:0] row_address;
  logic output_enable;

  led_matrix_multiplex_scanner #(
    .PANEL_WIDTH(PANEL_WIDTH),
    .PANEL_ROWS (PANEL_ROWS),
    .ROW_BYTES  (ROW_BYTES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .plane        (plane),
    .pixel_row    (pixel_row),
    .byte_index   (byte_index),
    .byte_value   (byte_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_lines    (red_lines),
    .green_lines  (green_lines),
    .shift_clock  (shift_clock),
    .strobe_res   (strobe_res),
    .row_address  (row_address),
    .output_enable(output_enable)
  );

  // Predictor state: framebuffer, scan position, pin state and register copies.
  logic [7:0]          fb_red   [FB_DEPTH];
  logic [7:0]          fb_green [FB_DEPTH];
  logic [LOCAL_W-1:0]  scan_row;
  logic [PERIOD_W-1:0] scan_count;
  logic [LOCAL_W-1:0]  latched_addr;
  logic                panel_lit;
  logic [PERIOD_W-1:0] cfg_period;
  logic                cfg_reverse;
  logic                cfg_level;

  pins_t pending_pins[$];
  pins_t seen_pins;
  pins_t want_pins;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the pin levels that one accepted request leaves, and advances the scan.
  function automatic pins_t predict_panel_pins(scan_req_t r);
    pins_t p;
    int    c;
    int    col;
    int    row;
    int    idx;
    p = '0;
    if (r.kind == KIND_WRITE) begin
      if (int'(r.pixel_row) < PANEL_ROWS && int'(r.byte_index) < ROW_BYTES) begin
        idx = int'(r.pixel_row) * ROW_BYTES + int'(r.byte_index);
        if (r.plane == PLANE_GREEN) fb_green[idx] = r.byte_value;
        else fb_red[idx] = r.byte_value;
      end
    end else begin
      c = int'(scan_count);
      if (c < PANEL_WIDTH) begin
        // Shift phase: one column per tick, every section in parallel.
        col = cfg_reverse ? PANEL_WIDTH - 1 - c : c;
        panel_lit = 1'b0;
        p.sclk = 1'b1;
        for (int s = 0; s < SECTIONS; s++) begin
          row = s * SECTION_ROWS + int'(scan_row);
          if (row < PANEL_ROWS && (col >> 3) < ROW_BYTES) begin
            idx = row * ROW_BYTES + (col >> 3);
            p.red[s]   = fb_red[idx][col & 7];
            p.green[s] = fb_green[idx][col & 7];
          end
        end
      end else if (c == PANEL_WIDTH) begin
        panel_lit = 1'b0;
        latched_addr = scan_row;
        p.strobe = 1'b1;
      end else begin
        panel_lit = 1'b1;
      end
      // The period ends after at least one tick, whatever the register holds.
      if (c + 1 >= int'(cfg_period)) begin
        scan_count = '0;
        scan_row = scan_row + 1'b1;
      end else begin
        scan_count = PERIOD_W'(c + 1);
      end
    end
    p.addr = latched_addr;
    p.oe = panel_lit ? cfg_level : ~cfg_level;
    return p;
  endfunction

  function automatic scan_req_t make_request(logic k, logic pl, int row, int bi, int val);
    scan_req_t r;
    r.kind = k;
    r.plane = pl;
    r.pixel_row = 6'(row);
    r.byte_index = 5'(bi);
    r.byte_value = 8'(val);
    return r;
  endfunction

  // Random request: mostly ticks, writes mostly inside the stored bytes.
  function automatic scan_req_t random_request(int tick_pct);
    scan_req_t r;
    r.kind = ($urandom_range(99) < tick_pct) ? KIND_TICK : KIND_WRITE;
    r.plane = 1'($urandom_range(1));
    r.pixel_row = 6'($urandom_range(63));
    if ($urandom_range(99) < 85) r.byte_index = 5'($urandom_range(ROW_BYTES - 1));
    else r.byte_index = 5'($urandom_range(31, ROW_BYTES));
    r.byte_value = 8'($urandom_range(255));
    return r;
  endfunction

  // Offers one request from a falling edge and returns at the falling edge after acceptance.
  task automatic send_request(scan_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    kind       <= r.kind;
    plane      <= r.plane;
    pixel_row  <= r.pixel_row;
    byte_index <= r.byte_index;
    byte_value <= r.byte_value;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pins.push_back(predict_panel_pins(r));
    @(negedge clk);
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic settle_bus();
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ROW_PERIOD:       cfg_period = val;
      REG_COLUMNS_REVERSED: cfg_reverse = val[0];
      REG_ENABLE_LEVEL:     cfg_level = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Registers are only rewritten once the block has gone quiet.
  task automatic apply_settings(int period, logic reversed, logic level);
    settle_bus();
    write_reg(REG_ROW_PERIOD, PERIOD_W'(period));
    write_reg(REG_COLUMNS_REVERSED, PERIOD_W'(reversed));
    write_reg(REG_ENABLE_LEVEL, PERIOD_W'(level));
  endtask

  task automatic run_random_items(int count);
    for (int i = 0; i < count; i++) send_request(random_request(80));
  endtask

  // Extreme writes, ignored writes, column order, one-tick periods and enable polarity.
  task automatic test_directed_edges();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(make_request(KIND_WRITE, PLANE_RED, 0, 0, 8'hFF));
    send_request(make_request(KIND_WRITE, PLANE_GREEN, 16, 0, 8'h01));
    send_request(make_request(KIND_WRITE, PLANE_RED, 47, ROW_BYTES - 1, 8'h80));
    send_request(make_request(KIND_WRITE, PLANE_GREEN, 63, ROW_BYTES - 1, 8'h80));
    // These two lie past the row's bytes and must leave the framebuffer alone.
    send_request(make_request(KIND_WRITE, PLANE_RED, 63, 31, 8'hFF));
    send_request(make_request(KIND_WRITE, PLANE_GREEN, 0, ROW_BYTES, 8'hFF));
    send_request(make_request(KIND_TICK, PLANE_RED, 0, 0, 0));
    send_request(make_request(KIND_TICK, PLANE_GREEN, 63, 31, 255));
    // A zero period ends after each tick, so every local row shifts the last column.
    apply_settings(0, 1'b1, 1'b1);
    for (int i = 0; i < 16; i++) send_request(make_request(KIND_TICK, i[0], i, i, i));
    send_request(make_request(KIND_WRITE, PLANE_RED, 5, 3, 8'h5A));
  endtask

  // Loads bytes into the rows about to be shifted and scans one full period at the
  // shortest legal length, running a few ticks into the next local row.
  task automatic test_frame_sweep(logic reversed, logic level);
    apply_settings(PANEL_WIDTH + 2, reversed, level);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 24; i++)
      send_request(make_request(KIND_WRITE, i[0],
                                ((i >> 1) % SECTIONS) * SECTION_ROWS + int'(scan_row),
                                $urandom_range(ROW_BYTES - 1), $urandom_range(255)));
    // Writes past the row end would land in the next row if the index wrapped.
    for (int i = 0; i < 4; i++)
      send_request(make_request(KIND_WRITE, 1'($urandom_range(1)), $urandom_range(63),
                                $urandom_range(31, ROW_BYTES), $urandom_range(255)));
    for (int i = 0; i < PANEL_WIDTH + 4; i++)
      send_request(make_request(KIND_TICK, 1'($urandom_range(1)), $urandom_range(63),
                                $urandom_range(31), $urandom_range(255)));
  endtask

  // Random traffic under each idling pattern and a spread of register settings.
  task automatic test_random_traffic();
    apply_settings(PANEL_WIDTH + 2, 1'b0, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_items(35);
    apply_settings($urandom_range(PANEL_WIDTH + 102, PANEL_WIDTH + 2), 1'b1, 1'b1);
    send_idle_pct = 72;
    recv_stall_pct = 0;
    run_random_items(35);
    apply_settings(65535, 1'($urandom_range(1)), 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 72;
    run_random_items(35);
    apply_settings($urandom_range(400, PANEL_WIDTH + 2), 1'b0, 1'b1);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    run_random_items(35);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    apply_settings(PANEL_WIDTH + 2, 1'b1, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 20;
    @(posedge clk);
    hold_req = 300;
    @(negedge clk);
    run_random_items(30);
  endtask

  // Receiver side: random stalls, or a long hold-off counted down here.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_pins = '{red: red_lines, green: green_lines, sclk: shift_clock,
                    strobe: strobe_res, addr: row_address, oe: output_enable};
      if (pending_pins.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("cycle %0d: result with nothing expected: %p", cycle_count, seen_pins);
      end else begin
        want_pins = pending_pins.pop_front();
        if (seen_pins.red !== want_pins.red || seen_pins.green !== want_pins.green ||
            seen_pins.sclk !== want_pins.sclk || seen_pins.strobe !== want_pins.strobe ||
            seen_pins.addr !== want_pins.addr || seen_pins.oe !== want_pins.oe) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("cycle %0d: mismatch, expected %p, got %p",
                     cycle_count, want_pins, seen_pins);
        end
      end
    end
  end

  // Guards against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < FB_DEPTH; i++) begin
      fb_red[i] = '0;
      fb_green[i] = '0;
    end
    scan_row = '0;
    scan_count = '0;
    latched_addr = '0;
    panel_lit = 1'b0;
    cfg_period = ROW_PERIOD_RESET;
    cfg_reverse = 1'b0;
    cfg_level = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_edges();
    test_frame_sweep(1'b0, 1'b0);
    test_random_traffic();
    test_backpressure();

    settle_bus();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_pins.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
